// ----- design/bufu_pkg.sv -----
package bufu_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned FILL_W = 8;

   typedef enum logic [1:0] {
      MODE_LINE_RX = 2'd0,
      MODE_HOST_RD = 2'd1,
      MODE_HOST_WR = 2'd2,
      MODE_TX_DONE = 2'd3
   } mode_type;

   // receive ring status, valid in the cycle after the transfer
   typedef struct packed {
      logic              rd_valid;
      logic              overflowed;
      logic [FILL_W-1:0] fill;
   } rx_stat_type;

   // transmit ring status, valid in the cycle after the transfer
   typedef struct packed {
      logic              send_load;
      logic              write_taken;
      logic              driver_on;
      logic [FILL_W-1:0] fill;
   } tx_stat_type;

endpackage

// ----- design/bufu_ram.sv -----
module bufu_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/bufu_rx_ring.sv -----
module bufu_rx_ring #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic                        pop_req,
   input  logic [bufu_pkg::BYTE_W-1:0] line_byte,
   output logic [bufu_pkg::BYTE_W-1:0] read_byte,
   output bufu_pkg::rx_stat_type       stat
);
   import bufu_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(DEPTH);

   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     tail_ff, tail_in;
   logic [FILL_W-1:0] count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              pop;
   logic [FILL_W-1:0] count_inc;
   logic [BYTE_W-1:0] rd_data;

   assign pop       = pop_req && (count_ff != '0);
   assign count_inc = count_ff + FILL_W'(1);

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      rd_valid_in = pop;
      if (push) begin
         head_in = (head_ff == LAST_IDX) ? '0 : head_ff + AW'(1);
         // count wraps to zero at depth; overflow is sticky
         if (count_inc == DEPTH_F) begin
            count_in = '0;
            ovf_in   = 1'b1;
         end else begin
            count_in = count_inc;
         end
      end else if (pop) begin
         tail_in  = (tail_ff == LAST_IDX) ? '0 : tail_ff + AW'(1);
         count_in = count_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   bufu_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (push),
      .wr_addr(head_ff),
      .wr_data(line_byte),
      .rd_en  (pop),
      .rd_addr(tail_ff),
      .rd_data(rd_data)
   );

   assign read_byte       = rd_valid_ff ? rd_data : '0;
   assign stat.rd_valid   = rd_valid_ff;
   assign stat.overflowed = ovf_ff;
   assign stat.fill       = count_ff;

   a_rx_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < DEPTH_F)
      else $error("rx count reached depth");

   a_rx_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> ($past(count_ff) != '0) && !$past(push))
      else $error("rx read returned data from an empty ring");

endmodule

// ----- design/bufu_tx_ring.sv -----
module bufu_tx_ring #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_req,
   input  logic                        done_req,
   input  logic [bufu_pkg::BYTE_W-1:0] host_byte,
   input  logic                        shifter_free,
   input  logic                        rs485_en,
   output logic [bufu_pkg::BYTE_W-1:0] send_byte,
   output bufu_pkg::tx_stat_type       stat
);
   import bufu_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(DEPTH);

   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     tail_ff, tail_in;
   logic [FILL_W-1:0] count_ff, count_in;
   logic              drv_ff, drv_in;
   logic              taken_ff, direct_ff, deq_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              full, empty, enq, direct, deq;
   logic [BYTE_W-1:0] rd_data;

   assign full   = (count_ff == DEPTH_F);
   assign empty  = (count_ff == '0);
   assign direct = wr_req && empty && shifter_free;
   assign enq    = wr_req && !full && !(empty && shifter_free);
   assign deq    = done_req && !empty;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      drv_in   = drv_ff;
      if (enq) begin
         head_in  = (head_ff == LAST_IDX) ? '0 : head_ff + AW'(1);
         count_in = count_ff + FILL_W'(1);
      end
      if (deq) begin
         tail_in  = (tail_ff == LAST_IDX) ? '0 : tail_ff + AW'(1);
         count_in = count_ff - FILL_W'(1);
      end
      if (rs485_en && direct) begin
         drv_in = 1'b1;
      end
      if (rs485_en && done_req && empty) begin
         drv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         drv_ff    <= 1'b0;
         taken_ff  <= 1'b0;
         direct_ff <= 1'b0;
         deq_ff    <= 1'b0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         drv_ff    <= drv_in;
         taken_ff  <= enq || direct;
         direct_ff <= direct;
         deq_ff    <= deq;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= host_byte;
   end

   bufu_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (enq),
      .wr_addr(head_ff),
      .wr_data(host_byte),
      .rd_en  (deq),
      .rd_addr(tail_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      priority if (deq_ff) begin
         send_byte = rd_data;
      end else if (direct_ff) begin
         send_byte = byte_ff;
      end else begin
         send_byte = '0;
      end
   end

   assign stat.send_load   = deq_ff || direct_ff;
   assign stat.write_taken = taken_ff;
   assign stat.driver_on   = drv_ff;
   assign stat.fill        = count_ff;

   a_tx_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_F)
      else $error("tx count beyond depth");

   a_tx_one_source: assert property (@(posedge clock) disable iff (reset)
      $onehot0({deq_ff, direct_ff}) && !(deq_ff && taken_ff))
      else $error("tx load from two sources");

endmodule

// ----- design/buffered_uart_fifo_pair_top.sv -----
// Receive and transmit byte rings around a serial port. Pulse start with a
// mode (line byte in, host read, host write, transmit complete) while busy
// is low; in the cycle after, the result appears for one cycle with
// rsp_strobe high. The receiver cannot stall, so the result must be taken
// in that cycle. One item is accepted per clock while busy is low: each
// item makes at most one access to each ring RAM, and the RAM read is
// registered. busy is high only during reset and in the first cycle after
// reset; there is no clearing pass. A write to the rs485_enable register
// through the csr_ channel should be made between items only.
module buffered_uart_fifo_pair_top #(
   parameter int unsigned RX_DEPTH = 64,
   parameter int unsigned TX_DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   // item channel
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_mode,
   input  logic [bufu_pkg::BYTE_W-1:0] req_line_byte,
   input  logic                        req_line_error,
   input  logic [bufu_pkg::BYTE_W-1:0] req_host_byte,
   input  logic                        req_shifter_free,
   // result channel
   output logic                        rsp_strobe,
   output logic [bufu_pkg::BYTE_W-1:0] rsp_read_byte,
   output logic                        rsp_read_valid,
   output logic [bufu_pkg::BYTE_W-1:0] rsp_send_byte,
   output logic                        rsp_send_load,
   output logic                        rsp_write_taken,
   output logic                        rsp_driver_on,
   output logic                        rsp_rx_overflowed,
   output logic [bufu_pkg::FILL_W-1:0] rsp_rx_fill,
   output logic [bufu_pkg::FILL_W-1:0] rsp_tx_fill,
   // configuration
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_rs485_enable
);
   import bufu_pkg::*;

   logic        busy_ff;
   logic        strobe_ff;
   logic        rs485_en_ff;
   logic        accept;
   logic        rx_push, rx_pop, tx_wr, tx_done;
   rx_stat_type rx_stat;
   tx_stat_type tx_stat;

   // busy is set during reset and clears once reset is released
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy      = busy_ff;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rs485_en_ff <= 1'b1;
      end else if (csr_valid) begin
         rs485_en_ff <= csr_rs485_enable;
      end
   end

   // mode decode; every ring state change happens at the accepting edge
   always_comb begin
      rx_push = 1'b0;
      rx_pop  = 1'b0;
      tx_wr   = 1'b0;
      tx_done = 1'b0;
      unique case (mode_type'(req_mode))
         MODE_LINE_RX: rx_push = accept && !req_line_error;
         MODE_HOST_RD: rx_pop  = accept;
         MODE_HOST_WR: tx_wr   = accept;
         MODE_TX_DONE: tx_done = accept;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
      end
   end

   bufu_rx_ring #(
      .DEPTH(RX_DEPTH)
   ) u_rx (
      .clock    (clock),
      .reset    (reset),
      .push     (rx_push),
      .pop_req  (rx_pop),
      .line_byte(req_line_byte),
      .read_byte(rsp_read_byte),
      .stat     (rx_stat)
   );

   bufu_tx_ring #(
      .DEPTH(TX_DEPTH)
   ) u_tx (
      .clock       (clock),
      .reset       (reset),
      .wr_req      (tx_wr),
      .done_req    (tx_done),
      .host_byte   (req_host_byte),
      .shifter_free(req_shifter_free),
      .rs485_en    (rs485_en_ff),
      .send_byte   (rsp_send_byte),
      .stat        (tx_stat)
   );

   assign rsp_strobe        = strobe_ff;
   assign rsp_read_valid    = rx_stat.rd_valid;
   assign rsp_rx_overflowed = rx_stat.overflowed;
   assign rsp_rx_fill       = rx_stat.fill;
   assign rsp_send_load     = tx_stat.send_load;
   assign rsp_write_taken   = tx_stat.write_taken;
   assign rsp_driver_on     = tx_stat.driver_on;
   assign rsp_tx_fill       = tx_stat.fill;

   a_flags_need_strobe: assert property (@(posedge clock) disable iff (reset)
      (rx_stat.rd_valid || tx_stat.send_load || tx_stat.write_taken) |-> strobe_ff)
      else $error("result flag without a transfer");

endmodule
